FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
// All checks are clocked on clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define APEG_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication
`define APEG_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: sv/apeg_pkg.sv
`timescale 1ns / 1ps

package apeg_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_IS_16BIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_IS_16BIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTH_POLARITIES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE      = 3'd4;

  // Request types
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  // 16-bit peaks reduced to 8 bit: divide by 256
  localparam int PEAK_SHIFT = 8;

  // Largest block size in sample frames
  localparam logic [CFG_DATA_W-1:0] BLOCK_MAX = 17'd65536;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_STATUS
  } apeg_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept_sample;  // sample transaction taken this cycle
    logic scan;           // peak-of-peaks pass, one channel
    logic emit;           // load next peak byte into output register
    logic status;         // load status-only result
    logic clear_all;      // flush done: back to reset state
  } apeg_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic frame_due;   // current sample completes a block
    logic bp_nonzero;  // complete sample frames pending
    logic chan_last;   // walk pointer on last channel
    logic emit_last;   // next byte is the last of the peak frame
    logic out_free;    // output register can take a result
  } apeg_stat_t;

endpackage

FILE: sv/apeg_ctrl.sv
`timescale 1ns / 1ps

module apeg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_req_type,
  output logic                in_stall,
  input  apeg_pkg::apeg_stat_t stat,
  output apeg_pkg::apeg_cmd_t  cmd
);

  apeg_pkg::apeg_state_t state_r, state_nxt;
  logic                  flush_r, flush_nxt;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apeg_pkg::ST_IDLE;
      flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      flush_r <= flush_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    flush_nxt = flush_r;
    case (state_r)
      apeg_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_req_type == apeg_pkg::REQ_FLUSH) begin
            flush_nxt = 1'b1;
            state_nxt = stat.bp_nonzero ? apeg_pkg::ST_SCAN : apeg_pkg::ST_STATUS;
          end else if (stat.frame_due) begin
            flush_nxt = 1'b0;
            state_nxt = apeg_pkg::ST_SCAN;
          end
        end
      end
      apeg_pkg::ST_SCAN: begin
        if (stat.chan_last) state_nxt = apeg_pkg::ST_EMIT;
      end
      apeg_pkg::ST_EMIT: begin
        if (stat.out_free && stat.emit_last) state_nxt = apeg_pkg::ST_IDLE;
      end
      apeg_pkg::ST_STATUS: begin
        if (stat.out_free) state_nxt = apeg_pkg::ST_IDLE;
      end
      default: state_nxt = apeg_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      apeg_pkg::ST_IDLE: begin
        in_stall          = 1'b0;
        cmd.accept_sample = in_valid && (in_req_type == apeg_pkg::REQ_SAMPLE);
      end
      apeg_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      apeg_pkg::ST_EMIT: begin
        cmd.emit      = stat.out_free;
        cmd.clear_all = stat.out_free && stat.emit_last && flush_r;
      end
      apeg_pkg::ST_STATUS: begin
        cmd.status    = stat.out_free;
        cmd.clear_all = stat.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

FILE: sv/apeg_dp.sv
`timescale 1ns / 1ps

module apeg_dp #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [apeg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [apeg_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input payload
  input  logic                               in_req_type,
  input  logic [15:0]                        in_sample,
  // result channel
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic [7:0]                         out_out_byte,
  output logic                               out_byte_valid,
  output logic                               out_last,
  output logic [15:0]                        out_top_peak,
  output logic [31:0]                        out_peak_frame_index,
  output logic [31:0]                        out_frame_count,
  // control
  input  apeg_pkg::apeg_cmd_t                cmd,
  output apeg_pkg::apeg_stat_t               stat
);

  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int BW    = apeg_pkg::CFG_DATA_W;

  // Configuration registers
  logic [3:0]    cfg_chan_cnt_r;
  logic          cfg_s16_r;
  logic          cfg_p16_r;
  logic          cfg_both_r;
  logic [BW-1:0] cfg_block_r;

  // Peak state
  logic [14:0]     pos_peak_r [MAX_CHANNELS];
  logic [15:0]     neg_mag_r  [MAX_CHANNELS];
  logic [CH_W-1:0] chan_idx_r;
  logic [BW-1:0]   block_pos_r;
  logic [31:0]     frames_done_r;
  logic [15:0]     top_peak_r;
  logic [31:0]     top_frame_r;

  // Walk over channels and bytes during scan / emission
  logic [CH_W-1:0] walk_c_r;
  logic [1:0]      walk_b_r;

  // Output register
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_bvalid_r;
  logic        out_last_r;
  logic [15:0] out_pop_r;
  logic [31:0] out_pfi_r;
  logic [31:0] out_fc_r;

  logic [CNT_W-1:0] eff_chans;
  logic [BW-1:0]    eff_block;
  logic [CH_W-1:0]  rd_idx;
  logic [14:0]      rd_pos;
  logic [15:0]      rd_neg;
  logic [15:0]      s16;
  logic [15:0]      neg_in;
  logic             upd_pos;
  logic             upd_neg;
  logic [CNT_W-1:0] ch_inc;
  logic             ch_wrap;
  logic [BW-1:0]    bp_inc;
  logic             divide;
  logic [15:0]      pv;
  logic [15:0]      qv;
  logic [15:0]      pe;
  logic [15:0]      mx;
  logic             b_last;
  logic             chan_last;
  logic             emit_last;
  logic             out_free;
  logic [7:0]       sel_byte;

  // Effective channel count and block size
  always_comb begin
    if (cfg_chan_cnt_r == 4'd0) begin
      eff_chans = CNT_W'(1);
    end else if (32'(cfg_chan_cnt_r) > MAX_CHANNELS) begin
      eff_chans = CNT_W'(MAX_CHANNELS);
    end else begin
      eff_chans = CNT_W'(cfg_chan_cnt_r);
    end
    if (cfg_block_r == '0) begin
      eff_block = BW'(1);
    end else if (cfg_block_r > apeg_pkg::BLOCK_MAX) begin
      eff_block = apeg_pkg::BLOCK_MAX;
    end else begin
      eff_block = cfg_block_r;
    end
  end

  // Single read port on the peak registers
  assign rd_idx = cmd.accept_sample ? chan_idx_r : walk_c_r;
  assign rd_pos = pos_peak_r[rd_idx];
  assign rd_neg = neg_mag_r[rd_idx];

  // Incoming sample: sign-extend and compare against stored peaks
  assign s16     = cfg_s16_r ? in_sample : {{8{in_sample[7]}}, in_sample[7:0]};
  assign neg_in  = ~s16 + 16'd1;
  assign upd_pos = !s16[15] && (s16[14:0] > rd_pos);
  assign upd_neg = s16[15] && (neg_in > rd_neg);
  assign ch_inc  = CNT_W'(chan_idx_r) + CNT_W'(1);
  assign ch_wrap = ch_inc >= eff_chans;
  assign bp_inc  = block_pos_r + BW'(1);

  // Peak values of the walked channel
  assign divide = cfg_s16_r && !cfg_p16_r;
  assign pv     = divide ? 16'(rd_pos >> apeg_pkg::PEAK_SHIFT) : 16'(rd_pos);
  assign qv     = divide ? (rd_neg >> apeg_pkg::PEAK_SHIFT) : rd_neg;
  assign pe     = (!cfg_both_r && (qv > pv)) ? qv : pv;
  assign mx     = (qv > pv) ? qv : pv;

  // Byte selection within one channel
  always_comb begin
    case ({cfg_p16_r, walk_b_r})
      3'b000:  sel_byte = pe[7:0];
      3'b001:  sel_byte = qv[7:0];
      3'b100:  sel_byte = pe[7:0];
      3'b101:  sel_byte = pe[15:8];
      3'b110:  sel_byte = qv[7:0];
      3'b111:  sel_byte = qv[15:8];
      default: sel_byte = 8'd0;
    endcase
    if (cfg_p16_r) begin
      b_last = cfg_both_r ? (walk_b_r == 2'd3) : (walk_b_r == 2'd1);
    end else begin
      b_last = cfg_both_r ? (walk_b_r == 2'd1) : (walk_b_r == 2'd0);
    end
  end

  assign chan_last = CNT_W'(walk_c_r) == (eff_chans - CNT_W'(1));
  assign emit_last = chan_last && b_last;
  assign out_free  = !out_valid_r || !out_stall;

  // Status to controller
  always_comb begin
    stat            = '0;
    stat.frame_due  = (in_req_type == apeg_pkg::REQ_SAMPLE) && ch_wrap && (bp_inc >= eff_block);
    stat.bp_nonzero = block_pos_r != '0;
    stat.chan_last  = chan_last;
    stat.emit_last  = emit_last;
    stat.out_free   = out_free;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_chan_cnt_r <= 4'd1;
      cfg_s16_r      <= 1'b1;
      cfg_p16_r      <= 1'b1;
      cfg_both_r     <= 1'b1;
      cfg_block_r    <= BW'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        apeg_pkg::CFG_CHANNEL_COUNT:   cfg_chan_cnt_r <= cfg_data[3:0];
        apeg_pkg::CFG_SAMPLE_IS_16BIT: cfg_s16_r      <= cfg_data[0];
        apeg_pkg::CFG_PEAK_IS_16BIT:   cfg_p16_r      <= cfg_data[0];
        apeg_pkg::CFG_BOTH_POLARITIES: cfg_both_r     <= cfg_data[0];
        apeg_pkg::CFG_BLOCK_SIZE:      cfg_block_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-channel peak registers
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_all || (cmd.emit && emit_last)) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        pos_peak_r[i] <= '0;
        neg_mag_r[i]  <= '0;
      end
    end else if (cmd.accept_sample) begin
      if (upd_pos) pos_peak_r[chan_idx_r] <= s16[14:0];
      if (upd_neg) neg_mag_r[chan_idx_r]  <= neg_in;
    end
  end

  // Channel and block position counters
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_all) begin
      chan_idx_r  <= '0;
      block_pos_r <= '0;
    end else if (cmd.accept_sample) begin
      if (ch_wrap) begin
        chan_idx_r  <= '0;
        block_pos_r <= (bp_inc >= eff_block) ? '0 : bp_inc;
      end else begin
        chan_idx_r  <= CH_W'(ch_inc);
      end
    end
  end

  // Peak of peaks and frame counter, updated during the scan pass
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_all) begin
      top_peak_r    <= '0;
      top_frame_r   <= '0;
      frames_done_r <= '0;
    end else if (cmd.scan) begin
      if (mx > top_peak_r) begin
        top_peak_r  <= mx;
        top_frame_r <= frames_done_r;
      end
      if (chan_last) frames_done_r <= frames_done_r + 32'd1;
    end
  end

  // Channel / byte walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_c_r <= '0;
      walk_b_r <= '0;
    end else if (cmd.scan) begin
      walk_c_r <= chan_last ? '0 : walk_c_r + CH_W'(1);
    end else if (cmd.emit) begin
      if (b_last) begin
        walk_b_r <= '0;
        walk_c_r <= chan_last ? '0 : walk_c_r + CH_W'(1);
      end else begin
        walk_b_r <= walk_b_r + 2'd1;
      end
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.status) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (cmd.emit || cmd.status) begin
      out_byte_r   <= cmd.emit ? sel_byte : 8'd0;
      out_bvalid_r <= cmd.emit;
      out_last_r   <= cmd.status || emit_last;
      out_pop_r    <= top_peak_r;
      out_pfi_r    <= top_frame_r;
      out_fc_r     <= frames_done_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_out_byte         = out_byte_r;
  assign out_byte_valid       = out_bvalid_r;
  assign out_last             = out_last_r;
  assign out_top_peak         = out_pop_r;
  assign out_peak_frame_index = out_pfi_r;
  assign out_frame_count      = out_fc_r;

endmodule

FILE: sv/audio_peak_envelope_generator.sv
`timescale 1ns / 1ps
// Peak envelope generator for interleaved signed PCM audio.
// Input channel (in_valid / in_stall): one transaction per sample, or a flush
// (in_req_type set). Samples arrive channel by channel; each sample frame
// is channel_count samples. Result channel (out_valid / out_stall): one
// transaction per peak byte, little-endian, with out_last on the final byte
// of a peak frame; peak-of-peaks, its frame index and the frame count ride
// along with every byte. Configuration is written through cfg_we /
// cfg_index / cfg_data while the block is idle; the user must keep to this,
// as the block itself does not enforce it. Throughput: a sample that does
// not close a block is taken every cycle. A sample closing a block (or a
// flush with complete sample frames pending) starts a scan pass over the
// channels, then loads one byte per cycle into the output register while
// the receiver does not stall; the input stays stalled until the last byte
// has been loaded. The single read port on the per-channel peak registers
// sets this pace. A flush with no full sample frame gives one status-only
// result (out_byte_valid low) once the output register is free.
// Stalling the receiver holds the output register and pauses byte loading;
// a waiting result does not block a new input transaction.
// Reset (synchronous, rst_n low) restores the default configuration and
// clears all peak state and counters; a flush clears the state likewise.

`include "assert_macros.svh"

module audio_peak_envelope_generator #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [apeg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apeg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_req_type,
  input  logic [15:0]                     in_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_out_byte,
  output logic                            out_byte_valid,
  output logic                            out_last,
  output logic [15:0]                     out_top_peak,
  output logic [31:0]                     out_peak_frame_index,
  output logic [31:0]                     out_frame_count
);

  apeg_pkg::apeg_cmd_t  cmd;
  apeg_pkg::apeg_stat_t stat;

  // Sequencer
  apeg_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  // Peak tracking and byte formatting
  apeg_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_req_type          (in_req_type),
    .in_sample            (in_sample),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_out_byte         (out_out_byte),
    .out_byte_valid       (out_byte_valid),
    .out_last             (out_last),
    .out_top_peak         (out_top_peak),
    .out_peak_frame_index (out_peak_frame_index),
    .out_frame_count      (out_frame_count),
    .cmd                  (cmd),
    .stat                 (stat)
  );

  // Checks
  `APEG_ASSERT_IMP(a_status_is_last, out_valid && !out_byte_valid, out_last, "status result without last")
  `APEG_ASSERT_IMP(a_status_zero_byte, out_valid && !out_byte_valid, out_out_byte == 8'd0, "status result carries data")
  `APEG_ASSERT_IMP(a_pop_range, out_valid, out_top_peak <= 16'd32768, "peak of peaks out of range")
  `APEG_ASSERT_NEXT(a_flush_stalls, in_valid && !in_stall && in_req_type, in_stall, "flush not followed by busy")

endmodule

FILE: test/audio_peak_envelope_generator_tb.sv
`timescale 1ns / 1ps

module audio_peak_envelope_generator_tb;

  localparam int NUM_CHANNELS    = 8;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int SETTLE_CYCLES   = 60;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 25;

  // One peak envelope byte as seen on the result channel
  typedef struct packed {
    logic [7:0]  pk_byte;
    logic        byte_ok;
    logic        last;
    logic [15:0] top_peak;
    logic [31:0] top_frame;
    logic [31:0] frames;
  } peak_beat_t;

  typedef enum logic {ROW_REG, ROW_ITEM} row_kind_t;

  // Directed stimulus row: either a register write or one input transaction
  typedef struct packed {
    row_kind_t                       kind;
    logic [apeg_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [apeg_pkg::CFG_DATA_W-1:0] reg_value;
    logic                            req;
    logic [15:0]                     smp;
    logic                            typed;
    peak_beat_t                      want;
  } stim_row_t;

  localparam peak_beat_t NO_BEAT = '0;
  // Flush straight after reset: status only, everything zero
  localparam peak_beat_t BEAT_EMPTY_FLUSH = '{8'h00, 1'b0, 1'b1, 16'd0, 32'd0, 32'd0};
  // Full-scale negative 16-bit sample, 8-bit peak: 32768 / 256 = 0x80
  localparam peak_beat_t BEAT_NEG_FULL = '{8'h80, 1'b1, 1'b1, 16'd128, 32'd0, 32'd1};
  // Full-scale positive: 32767 / 256 = 0x7f, peak of peaks stays
  localparam peak_beat_t BEAT_POS_FULL = '{8'h7f, 1'b1, 1'b1, 16'd128, 32'd0, 32'd2};
  // Flush with no complete frame pending keeps the counters in the status
  localparam peak_beat_t BEAT_LATE_FLUSH = '{8'h00, 1'b0, 1'b1, 16'd128, 32'd0, 32'd2};

  localparam stim_row_t DIRECTED_ROWS [35] = '{
    '{ROW_ITEM, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_FLUSH,
      16'h0000, 1'b1, BEAT_EMPTY_FLUSH},
    '{ROW_REG, apeg_pkg::CFG_BLOCK_SIZE, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'h0000, 1'b0, NO_BEAT},
    '{ROW_REG, apeg_pkg::CFG_PEAK_IS_16BIT, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'h0000, 1'b0, NO_BEAT},
    '{ROW_REG, apeg_pkg::CFG_BOTH_POLARITIES, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'h0000, 1'b0, NO_BEAT},
    '{ROW_ITEM, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'h8000, 1'b1, BEAT_NEG_FULL},
    '{ROW_ITEM, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'h7fff, 1'b1, BEAT_POS_FULL},
    '{ROW_ITEM, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_FLUSH,
      16'hffff, 1'b1, BEAT_LATE_FLUSH},
    // over-range channel count and block size, 8-bit samples, widest frame
    '{ROW_REG, apeg_pkg::CFG_CHANNEL_COUNT, 17'd15, apeg_pkg::REQ_SAMPLE,
      16'h0000, 1'b0, NO_BEAT},
    '{ROW_REG, apeg_pkg::CFG_SAMPLE_IS_16BIT, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'h0000, 1'b0, NO_BEAT},
    '{ROW_REG, apeg_pkg::CFG_PEAK_IS_16BIT, 17'd1, apeg_pkg::REQ_SAMPLE,
      16'h0000, 1'b0, NO_BEAT},
    '{ROW_REG, apeg_pkg::CFG_BOTH_POLARITIES, 17'd1, apeg_pkg::REQ_SAMPLE,
      16'h0000, 1'b0, NO_BEAT},
    '{ROW_REG, apeg_pkg::CFG_BLOCK_SIZE, 17'h1ffff, apeg_pkg::REQ_SAMPLE,
      16'h0000, 1'b0, NO_BEAT},
    '{ROW_ITEM, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'h0080, 1'b0, NO_BEAT},
    '{ROW_ITEM, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'hff7f, 1'b0, NO_BEAT},
    '{ROW_ITEM, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'h00ff, 1'b0, NO_BEAT},
    '{ROW_ITEM, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'h0001, 1'b0, NO_BEAT},
    '{ROW_ITEM, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'h1200, 1'b0, NO_BEAT},
    '{ROW_ITEM, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'hab80, 1'b0, NO_BEAT},
    '{ROW_ITEM, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'h007f, 1'b0, NO_BEAT},
    '{ROW_ITEM, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'h5a5a, 1'b0, NO_BEAT},
    '{ROW_ITEM, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_FLUSH,
      16'h0000, 1'b0, NO_BEAT},
    // three channels, then the count drops while a frame is half done
    '{ROW_REG, apeg_pkg::CFG_CHANNEL_COUNT, 17'd3, apeg_pkg::REQ_SAMPLE,
      16'h0000, 1'b0, NO_BEAT},
    '{ROW_REG, apeg_pkg::CFG_SAMPLE_IS_16BIT, 17'd1, apeg_pkg::REQ_SAMPLE,
      16'h0000, 1'b0, NO_BEAT},
    '{ROW_REG, apeg_pkg::CFG_PEAK_IS_16BIT, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'h0000, 1'b0, NO_BEAT},
    '{ROW_REG, apeg_pkg::CFG_BLOCK_SIZE, 17'd2, apeg_pkg::REQ_SAMPLE,
      16'h0000, 1'b0, NO_BEAT},
    '{ROW_ITEM, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'h8000, 1'b0, NO_BEAT},
    '{ROW_ITEM, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'h7fff, 1'b0, NO_BEAT},
    '{ROW_ITEM, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'h0000, 1'b0, NO_BEAT},
    '{ROW_ITEM, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'hff00, 1'b0, NO_BEAT},
    '{ROW_ITEM, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'h0100, 1'b0, NO_BEAT},
    '{ROW_REG, apeg_pkg::CFG_CHANNEL_COUNT, 17'd2, apeg_pkg::REQ_SAMPLE,
      16'h0000, 1'b0, NO_BEAT},
    '{ROW_ITEM, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'h4000, 1'b0, NO_BEAT},
    // zero channel count acts as one
    '{ROW_REG, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'h0000, 1'b0, NO_BEAT},
    '{ROW_ITEM, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_SAMPLE,
      16'hc000, 1'b0, NO_BEAT},
    '{ROW_ITEM, apeg_pkg::CFG_CHANNEL_COUNT, 17'd0, apeg_pkg::REQ_FLUSH,
      16'h0000, 1'b0, NO_BEAT}
  };

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [apeg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [apeg_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            in_req_type = apeg_pkg::REQ_SAMPLE;
  logic [15:0]                     in_sample = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [7:0]                      out_out_byte;
  logic                            out_byte_valid;
  logic                            out_last;
  logic [15:0]                     out_top_peak;
  logic [31:0]                     out_peak_frame_index;
  logic [31:0]                     out_frame_count;

  bit          idle_on = 1'b1;
  int unsigned cycle_count = 0;
  int          bad_fields = 0;
  peak_beat_t  peak_bytes_due[$];

  audio_peak_envelope_generator dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_sample            (in_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_out_byte         (out_out_byte),
    .out_byte_valid       (out_byte_valid),
    .out_last             (out_last),
    .out_top_peak         (out_top_peak),
    .out_peak_frame_index (out_peak_frame_index),
    .out_frame_count      (out_frame_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver back-pressure in random bursts
  initial begin
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch on %s: got %0h, want %0h at %0t", what, got, want, $time);
    bad_fields++;
  endtask

  // Result transactions checked against the oldest expected byte
  always @(posedge clk) begin : result_check
    peak_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (peak_bytes_due.size() == 0) begin
        note_mismatch("unexpected result", 32'(out_out_byte), 32'd0);
      end else begin
        want = peak_bytes_due.pop_front();
        if (out_out_byte != want.pk_byte)
          note_mismatch("out_byte", 32'(out_out_byte), 32'(want.pk_byte));
        if (out_byte_valid != want.byte_ok)
          note_mismatch("byte_valid", 32'(out_byte_valid), 32'(want.byte_ok));
        if (out_last != want.last)
          note_mismatch("last", 32'(out_last), 32'(want.last));
        if (out_top_peak != want.top_peak)
          note_mismatch("top_peak", 32'(out_top_peak), 32'(want.top_peak));
        if (out_peak_frame_index != want.top_frame)
          note_mismatch("peak_frame_index", out_peak_frame_index, want.top_frame);
        if (out_frame_count != want.frames)
          note_mismatch("frame_count", out_frame_count, want.frames);
      end
    end
  end

  // Predictor: register copies and peak state
  logic [3:0]                      cfg_channels = 4'd1;
  logic                            cfg_s16 = 1'b1;
  logic                            cfg_p16 = 1'b1;
  logic                            cfg_both = 1'b1;
  logic [apeg_pkg::CFG_DATA_W-1:0] cfg_block = 17'd256;

  int unsigned pos_pk [NUM_CHANNELS] = '{default: 0};
  int unsigned neg_pk [NUM_CHANNELS] = '{default: 0};
  int unsigned chan_ptr = 0;
  int unsigned frames_in_block = 0;
  int unsigned frames_emitted = 0;
  int unsigned best_peak = 0;
  int unsigned best_frame = 0;

  function automatic int unsigned active_channels();
    if (cfg_channels == 0) return 1;
    if (cfg_channels > NUM_CHANNELS) return NUM_CHANNELS;
    return cfg_channels;
  endfunction

  // Builds one peak frame from the held peaks, queues its bytes, returns the count
  function automatic int close_peak_frame();
    logic [7:0]  frame_bytes[$];
    int unsigned p, q, top;
    peak_beat_t  beat;
    for (int c = 0; c < active_channels(); c++) begin
      p = pos_pk[c];
      q = neg_pk[c];
      if (cfg_s16 && !cfg_p16) begin
        p = p >> apeg_pkg::PEAK_SHIFT;
        q = q >> apeg_pkg::PEAK_SHIFT;
      end
      if (!cfg_both && q > p) p = q;
      top = best_peak;
      if (p > top) top = p;
      if (q > top) top = q;
      if (top > best_peak) best_frame = frames_emitted;
      best_peak = top;
      frame_bytes.push_back(p[7:0]);
      if (cfg_p16) frame_bytes.push_back(p[15:8]);
      if (cfg_both) begin
        frame_bytes.push_back(q[7:0]);
        if (cfg_p16) frame_bytes.push_back(q[15:8]);
      end
    end
    // every channel slot is cleared, not only the active ones
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      pos_pk[c] = 0;
      neg_pk[c] = 0;
    end
    frames_emitted++;
    foreach (frame_bytes[k]) begin
      beat.pk_byte   = frame_bytes[k];
      beat.byte_ok   = 1'b1;
      beat.last      = (k == frame_bytes.size() - 1);
      beat.top_peak  = best_peak[15:0];
      beat.top_frame = best_frame;
      beat.frames    = frames_emitted;
      peak_bytes_due.push_back(beat);
    end
    return frame_bytes.size();
  endfunction

  // Advances the envelope state by one input transaction; returns bytes queued
  function automatic int predict_envelope(input logic req, input logic [15:0] smp);
    int          s;
    int unsigned ch, blk;
    int          produced;
    peak_beat_t  beat;
    produced = 0;
    if (req == apeg_pkg::REQ_SAMPLE) begin
      if (cfg_s16) s = $signed(smp);
      else s = $signed(smp[7:0]);
      ch = (chan_ptr >= NUM_CHANNELS) ? 0 : chan_ptr;
      if (s > 0 && unsigned'(s) > pos_pk[ch]) pos_pk[ch] = s;
      if (s < 0 && unsigned'(-s) > neg_pk[ch]) neg_pk[ch] = -s;
      ch++;
      // a lowered channel count wraps as soon as the pointer reaches it
      if (ch >= active_channels()) begin
        ch = 0;
        frames_in_block++;
        blk = (cfg_block == 0) ? 1 :
              (cfg_block > apeg_pkg::BLOCK_MAX) ? apeg_pkg::BLOCK_MAX : cfg_block;
        if (frames_in_block >= blk) begin
          produced = close_peak_frame();
          frames_in_block = 0;
        end
      end
      chan_ptr = ch;
    end else begin
      // partial sample frames are dropped unless complete ones are pending; then all held peaks are emitted
      if (frames_in_block != 0) produced = close_peak_frame();
      if (produced == 0) begin
        beat.pk_byte   = 8'h00;
        beat.byte_ok   = 1'b0;
        beat.last      = 1'b1;
        beat.top_peak  = best_peak[15:0];
        beat.top_frame = best_frame;
        beat.frames    = frames_emitted;
        peak_bytes_due.push_back(beat);
        produced = 1;
      end
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        pos_pk[c] = 0;
        neg_pk[c] = 0;
      end
      chan_ptr = 0;
      frames_in_block = 0;
      frames_emitted = 0;
      best_peak = 0;
      best_frame = 0;
    end
    return produced;
  endfunction

  task automatic write_reg(input logic [apeg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [apeg_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      apeg_pkg::CFG_CHANNEL_COUNT:   cfg_channels = value[3:0];
      apeg_pkg::CFG_SAMPLE_IS_16BIT: cfg_s16 = value[0];
      apeg_pkg::CFG_PEAK_IS_16BIT:   cfg_p16 = value[0];
      apeg_pkg::CFG_BOTH_POLARITIES: cfg_both = value[0];
      apeg_pkg::CFG_BLOCK_SIZE:      cfg_block = value;
      default: ;
    endcase
  endtask

  // One input transaction, with an optional random gap ahead of it
  task automatic send_item(input logic req, input logic [15:0] smp, output int produced);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_sample   <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    produced = predict_envelope(req, smp);
  endtask

  // Drain: all expected bytes out, then let the block finish internally
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (peak_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    stim_row_t                       row;
    logic                            req;
    logic [15:0]                     smp;
    logic [apeg_pkg::CFG_DATA_W-1:0] blk;
    logic [3:0]                      chans;
    int                              produced;
    logic                            last_was_item;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    last_was_item = 1'b0;
    foreach (DIRECTED_ROWS[r]) begin
      row = DIRECTED_ROWS[r];
      if (row.kind == ROW_REG) begin
        if (last_was_item) settle();
        write_reg(row.reg_idx, row.reg_value);
        last_was_item = 1'b0;
      end else begin
        send_item(row.req, row.smp, produced);
        if (row.typed) begin
          repeat (produced) void'(peak_bytes_due.pop_back());
          peak_bytes_due.push_back(row.want);
        end
        last_was_item = 1'b1;
      end
    end

    // Random phases, each with a fresh register setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      if (ph == RANDOM_PHASES - 1) idle_on = 1'b0;
      if ($urandom_range(0, 3) == 0) chans = 4'($urandom_range(0, 15));
      else chans = 4'($urandom_range(1, 8));
      case ($urandom_range(0, 7))
        0:       blk = 17'($urandom_range(0, 17'h1ffff));
        1:       blk = '0;
        default: blk = 17'($urandom_range(1, 3));
      endcase
      write_reg(apeg_pkg::CFG_CHANNEL_COUNT, 17'(chans));
      write_reg(apeg_pkg::CFG_SAMPLE_IS_16BIT, 17'($urandom_range(0, 1)));
      write_reg(apeg_pkg::CFG_PEAK_IS_16BIT, 17'($urandom_range(0, 1)));
      write_reg(apeg_pkg::CFG_BOTH_POLARITIES, 17'($urandom_range(0, 1)));
      write_reg(apeg_pkg::CFG_BLOCK_SIZE, blk);
      repeat (ITEMS_PER_PHASE) begin
        req = ($urandom_range(0, 11) == 0) ? apeg_pkg::REQ_FLUSH : apeg_pkg::REQ_SAMPLE;
        case ($urandom_range(0, 9))
          0:       smp = 16'h8000;
          1:       smp = 16'h7fff;
          2:       smp = 16'hff80;
          default: smp = 16'($urandom);
        endcase
        send_item(req, smp, produced);
      end
    end

    settle();
    if (bad_fields == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/apeg_pkg.sv
sv/apeg_ctrl.sv
sv/apeg_dp.sv
sv/audio_peak_envelope_generator.sv
test/audio_peak_envelope_generator_tb.sv
